// File: hdl/tzol_pkg.sv
// shared types, constants and helper functions for the tzif offset lookup block
package tzol_pkg;

    // header length and field positions
    localparam int unsigned HDR_LEN    = 44;
    localparam int unsigned HDR_FIELDS = 20;

    // load report codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC1 = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC2 = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_FIXED_MODE   = 1'b0;
    localparam logic CFG_FIXED_OFFSET = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR1   = 4'd0,
        PH_SKIP1  = 4'd1,
        PH_HDR2   = 4'd2,
        PH_TIMES  = 4'd3,
        PH_TYPES  = 4'd4,
        PH_TTINFO = 4'd5,
        PH_CHARS  = 4'd6,
        PH_DONE   = 4'd7,
        PH_DRAIN  = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TYPE,
        S_SUM
    } t_state;

    typedef enum logic [1:0] {
        QM_NONE,
        QM_FIXED,
        QM_TABLE
    } t_qmode;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic walk_start;
        logic walk_step;
        logic type_rd;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic need_walk;
        logic walk_done;
    } t_dp_stat;

    // expected magic "TZif"
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        unique case (pos)
            2'd0: m = 8'h54;
            2'd1: m = 8'h5A;
            2'd2: m = 8'h69;
            default: m = 8'h66;
        endcase
        return m;
    endfunction

    // first non-empty section from the given one on
    function automatic t_phase enter_phase(input t_phase from, input logic [31:0] tc,
                                           input logic [31:0] ty, input logic [31:0] cc);
        t_phase ph;
        ph = from;
        if (ph == PH_TIMES && tc == 32'd0) ph = PH_TYPES;
        if (ph == PH_TYPES && tc == 32'd0) ph = PH_TTINFO;
        if (ph == PH_TTINFO && ty == 32'd0) ph = PH_CHARS;
        if (ph == PH_CHARS && cc == 32'd0) ph = PH_DONE;
        return ph;
    endfunction

endpackage

// File: hdl/tzol_ctrl.sv
// controller state machine: accept, table walk, type fetch and result hand-off
module tzol_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  tzol_pkg::t_dp_stat i_stat,
    output tzol_pkg::t_dp_cmd  o_cmd
);

    tzol_pkg::t_state r_state;
    tzol_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tzol_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tzol_pkg::S_IDLE: begin
                if (i_stat.out_free && i_in_valid && i_kind == tzol_pkg::KIND_QUERY) begin
                    n_state = i_stat.need_walk ? tzol_pkg::S_WALK : tzol_pkg::S_SUM;
                end
            end
            tzol_pkg::S_WALK: begin
                if (i_stat.walk_done) n_state = tzol_pkg::S_TYPE;
            end
            tzol_pkg::S_TYPE: n_state = tzol_pkg::S_SUM;
            tzol_pkg::S_SUM: begin
                if (i_stat.out_free) n_state = tzol_pkg::S_IDLE;
            end
            default: n_state = tzol_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tzol_pkg::S_IDLE: begin
                o_cmd.accept     = i_stat.out_free;
                o_cmd.walk_start = i_stat.out_free && i_in_valid &&
                                   i_kind == tzol_pkg::KIND_QUERY;
            end
            tzol_pkg::S_WALK: o_cmd.walk_step = 1'b1;
            tzol_pkg::S_TYPE: o_cmd.type_rd = 1'b1;
            tzol_pkg::S_SUM:  o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/tzol_dp.sv
// datapath: byte parser, transition and type tables, walk compare and output register
module tzol_dp #(
    parameter int MAX_TRANSITIONS = 512,
    parameter int MAX_TYPES       = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tzol_pkg::t_dp_cmd  i_cmd,
    output tzol_pkg::t_dp_stat o_stat,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic signed [63:0] i_query_seconds,
    input  logic               i_fixed_mode,
    input  logic signed [17:0] i_fixed_offset,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_result_kind,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_offset_seconds,
    output logic [7:0]         o_abbrev_idx,
    output logic signed [63:0] o_local_seconds
);

    localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int TW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

    // tables
    logic [63:0] times_mem [MAX_TRANSITIONS];
    logic [7:0]  types_mem [MAX_TRANSITIONS];
    logic [31:0] toff_mem  [MAX_TYPES];
    logic [7:0]  tabbr_mem [MAX_TYPES];

    // parser state
    tzol_pkg::t_phase r_phase, n_phase;
    logic [39:0] r_cnt, n_cnt;
    logic [63:0] r_asm, n_asm;
    logic [39:0] r_skip, n_skip;
    logic [31:0] r_tc, n_tc;
    logic [31:0] r_ty, n_ty;
    logic [31:0] r_cc, n_cc;
    logic        r_tvalid, n_tvalid;
    logic        r_mbad, n_mbad;
    logic [2:0]  r_sub, n_sub;
    logic [TW-1:0] r_ent, n_ent;

    // query state
    tzol_pkg::t_qmode r_qmode;
    logic signed [63:0] r_q;
    logic [AW:0]   r_widx;
    logic          r_rd_ok;
    logic          r_wdone;
    logic          r_found;
    logic [7:0]    r_typ;
    logic [63:0]   r_time_rd;
    logic [7:0]    r_type_rd;
    logic [31:0]   r_toff_rd;
    logic [7:0]    r_tabbr_rd;

    // output register
    logic r_ovalid;

    logic load_fire;
    logic rep;
    logic [2:0] rep_st;
    logic times_we, types_we, toff_we, tabbr_we;
    logic [AW-1:0] times_wa, types_wa;
    logic [TW-1:0] ent_wa;
    logic [63:0] times_wd;
    logic [31:0] toff_wd;
    logic [AW:0] walk_n;
    logic [TW-1:0] typ_sel;

    assign load_fire = i_cmd.accept && i_in_valid && i_kind == tzol_pkg::KIND_LOAD;
    assign walk_n    = r_tc[AW:0];

    // status to controller
    assign o_stat.out_free  = !r_ovalid || !i_out_stall;
    assign o_stat.need_walk = !i_fixed_mode && r_tvalid && r_ty != 32'd0;
    assign o_stat.walk_done = r_wdone;

    // byte parser
    always_comb begin
        logic [39:0] pos;
        logic [39:0] pos1;
        logic        second;
        logic [63:0] asm_v;
        logic [31:0] v;
        logic [39:0] skip_v;
        logic [31:0] tc_v, ty_v, cc_v;
        logic        mbad_v;
        logic [3:0]  k;
        logic [39:0] w;
        logic [34:0] ty6;
        tzol_pkg::t_phase ph;

        pos    = r_cnt;
        pos1   = r_cnt + 40'd1;
        second = (r_phase == tzol_pkg::PH_HDR2);
        asm_v  = {r_asm[55:0], i_data_byte};
        v      = asm_v[31:0];
        skip_v = r_skip;
        tc_v   = r_tc;
        ty_v   = r_ty;
        cc_v   = r_cc;
        mbad_v = r_mbad;
        k      = pos[5:2] - 4'd5;
        w      = 40'd0;
        ty6    = {1'b0, r_ty, 2'b00} + {2'b00, r_ty, 1'b0};
        ph     = r_phase;

        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_asm    = r_asm;
        n_skip   = r_skip;
        n_tc     = r_tc;
        n_ty     = r_ty;
        n_cc     = r_cc;
        n_tvalid = r_tvalid;
        n_mbad   = r_mbad;
        n_sub    = r_sub;
        n_ent    = r_ent;
        rep      = 1'b0;
        rep_st   = tzol_pkg::ST_OK;
        times_we = 1'b0;
        types_we = 1'b0;
        toff_we  = 1'b0;
        tabbr_we = 1'b0;
        times_wa = pos[AW+2:3];
        types_wa = pos[AW-1:0];
        ent_wa   = r_ent;
        times_wd = asm_v;
        toff_wd  = v;

        if (load_fire) begin
            unique case (r_phase)
                tzol_pkg::PH_HDR1, tzol_pkg::PH_HDR2: begin
                    if (!second && pos == 40'd0) begin
                        n_tvalid = 1'b0;
                        skip_v   = 40'd0;
                        mbad_v   = 1'b0;
                    end
                    n_asm = asm_v;
                    if (pos < 40'd4 && i_data_byte != tzol_pkg::magic_byte(pos[1:0])) begin
                        mbad_v = 1'b1;
                    end
                    if (pos >= 40'(tzol_pkg::HDR_FIELDS) && pos[1:0] == 2'd3) begin
                        if (!second) begin
                            // weights of the v1 counts in the body length
                            unique case (k)
                                4'd0, 4'd1, 4'd5: w = {8'd0, v};
                                4'd2: w = {5'd0, v, 3'd0};
                                4'd3: w = {6'd0, v, 2'd0} + {8'd0, v};
                                4'd4: w = {6'd0, v, 2'd0} + {7'd0, v, 1'b0};
                                default: w = 40'd0;
                            endcase
                            skip_v = skip_v + w;
                        end else begin
                            unique case (k)
                                4'd3: tc_v = v;
                                4'd4: ty_v = v;
                                4'd5: cc_v = v;
                                default: ;
                            endcase
                        end
                    end
                    n_mbad = mbad_v;
                    n_skip = skip_v;
                    n_tc   = tc_v;
                    n_ty   = ty_v;
                    n_cc   = cc_v;
                    n_cnt  = pos1;
                    if (pos1 >= 40'(tzol_pkg::HDR_LEN)) begin
                        n_cnt = 40'd0;
                        n_asm = 64'd0;
                        n_sub = 3'd0;
                        n_ent = '0;
                        if (mbad_v) begin
                            n_phase = tzol_pkg::PH_DRAIN;
                            rep     = 1'b1;
                            rep_st  = second ? tzol_pkg::ST_BAD_MAGIC2
                                             : tzol_pkg::ST_BAD_MAGIC1;
                        end else if (!second) begin
                            n_phase = (skip_v == 40'd0) ? tzol_pkg::PH_HDR2
                                                        : tzol_pkg::PH_SKIP1;
                        end else if (tc_v > 32'(MAX_TRANSITIONS) || ty_v > 32'(MAX_TYPES)) begin
                            n_phase = tzol_pkg::PH_DRAIN;
                            rep     = 1'b1;
                            rep_st  = tzol_pkg::ST_TOO_LARGE;
                        end else begin
                            ph      = tzol_pkg::enter_phase(tzol_pkg::PH_TIMES, tc_v, ty_v, cc_v);
                            n_phase = ph;
                            if (ph == tzol_pkg::PH_DONE) begin
                                n_tvalid = 1'b1;
                                rep      = 1'b1;
                            end
                        end
                    end
                end
                tzol_pkg::PH_SKIP1: begin
                    n_cnt = pos1;
                    if (pos1 >= r_skip) begin
                        n_cnt   = 40'd0;
                        n_mbad  = 1'b0;
                        n_phase = tzol_pkg::PH_HDR2;
                    end
                end
                tzol_pkg::PH_TIMES: begin
                    n_asm    = asm_v;
                    times_we = (pos[2:0] == 3'd7);
                    n_cnt    = pos1;
                    if (pos1 >= {5'd0, r_tc, 3'd0}) begin
                        ph      = tzol_pkg::enter_phase(tzol_pkg::PH_TYPES, r_tc, r_ty, r_cc);
                        n_phase = ph;
                        n_cnt   = 40'd0;
                        n_asm   = 64'd0;
                        if (ph == tzol_pkg::PH_DONE) begin
                            n_tvalid = 1'b1;
                            rep      = 1'b1;
                        end
                    end
                end
                tzol_pkg::PH_TYPES: begin
                    types_we = 1'b1;
                    n_cnt    = pos1;
                    if (pos1 >= {8'd0, r_tc}) begin
                        ph      = tzol_pkg::enter_phase(tzol_pkg::PH_TTINFO, r_tc, r_ty, r_cc);
                        n_phase = ph;
                        n_cnt   = 40'd0;
                        n_asm   = 64'd0;
                        if (ph == tzol_pkg::PH_DONE) begin
                            n_tvalid = 1'b1;
                            rep      = 1'b1;
                        end
                    end
                end
                tzol_pkg::PH_TTINFO: begin
                    if (r_sub < 3'd4) n_asm = asm_v;
                    toff_we  = (r_sub == 3'd3);
                    tabbr_we = (r_sub == 3'd5);
                    // six bytes per type entry
                    if (r_sub == 3'd5) begin
                        n_sub = 3'd0;
                        n_ent = r_ent + 1'b1;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                    n_cnt = pos1;
                    if (pos1 >= {5'd0, ty6}) begin
                        ph      = tzol_pkg::enter_phase(tzol_pkg::PH_CHARS, r_tc, r_ty, r_cc);
                        n_phase = ph;
                        n_cnt   = 40'd0;
                        n_asm   = 64'd0;
                        if (ph == tzol_pkg::PH_DONE) begin
                            n_tvalid = 1'b1;
                            rep      = 1'b1;
                        end
                    end
                end
                tzol_pkg::PH_CHARS: begin
                    n_cnt = pos1;
                    if (pos1 >= {8'd0, r_cc}) begin
                        n_phase  = tzol_pkg::PH_DONE;
                        n_cnt    = 40'd0;
                        n_asm    = 64'd0;
                        n_tvalid = 1'b1;
                        rep      = 1'b1;
                    end
                end
                default: ;
            endcase

            // file ends early
            if (!rep && i_last_byte && n_phase != tzol_pkg::PH_DONE &&
                n_phase != tzol_pkg::PH_DRAIN) begin
                rep      = 1'b1;
                rep_st   = tzol_pkg::ST_TRUNCATED;
                n_tvalid = 1'b0;
            end
            if (i_last_byte) begin
                n_phase = tzol_pkg::PH_HDR1;
                n_cnt   = 40'd0;
                n_asm   = 64'd0;
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tzol_pkg::PH_HDR1;
            r_cnt    <= 40'd0;
            r_asm    <= 64'd0;
            r_skip   <= 40'd0;
            r_tc     <= 32'd0;
            r_ty     <= 32'd0;
            r_cc     <= 32'd0;
            r_tvalid <= 1'b0;
            r_mbad   <= 1'b0;
            r_sub    <= 3'd0;
            r_ent    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_asm    <= n_asm;
            r_skip   <= n_skip;
            r_tc     <= n_tc;
            r_ty     <= n_ty;
            r_cc     <= n_cc;
            r_tvalid <= n_tvalid;
            r_mbad   <= n_mbad;
            r_sub    <= n_sub;
            r_ent    <= n_ent;
        end
    end

    // transition tables, one write and one registered read port each
    always_ff @(posedge i_clk) begin
        if (times_we) times_mem[times_wa] <= times_wd;
        if (types_we) types_mem[types_wa] <= i_data_byte;
        r_time_rd <= times_mem[r_widx[AW-1:0]];
        r_type_rd <= types_mem[r_widx[AW-1:0]];
    end

    // type entry table
    assign typ_sel = (r_found && {24'd0, r_typ} < r_ty && 32'(r_typ) < 32'(MAX_TYPES))
                     ? r_typ[TW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (toff_we)  toff_mem[ent_wa]  <= toff_wd;
        if (tabbr_we) tabbr_mem[ent_wa] <= i_data_byte;
        if (i_cmd.type_rd) begin
            r_toff_rd  <= toff_mem[typ_sel];
            r_tabbr_rd <= tabbr_mem[typ_sel];
        end
    end

    // query capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode <= tzol_pkg::QM_NONE;
        end else if (i_cmd.walk_start) begin
            if (i_fixed_mode)          r_qmode <= tzol_pkg::QM_FIXED;
            else if (o_stat.need_walk) r_qmode <= tzol_pkg::QM_TABLE;
            else                       r_qmode <= tzol_pkg::QM_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) r_q <= i_query_seconds;
    end

    // ordered walk: read one time per cycle, compare it in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= '0;
            r_rd_ok <= 1'b0;
            r_wdone <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_widx  <= '0;
            r_rd_ok <= 1'b0;
            r_wdone <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.walk_step && !r_wdone) begin
            r_rd_ok <= (r_widx < walk_n);
            if (r_widx < walk_n) r_widx <= r_widx + 1'b1;
            if (walk_n == '0) begin
                r_wdone <= 1'b1;
            end else if (r_rd_ok) begin
                if (r_q >= $signed(r_time_rd)) begin
                    r_found <= 1'b1;
                    if (r_widx == walk_n) r_wdone <= 1'b1;
                end else begin
                    r_wdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && !r_wdone && r_rd_ok && r_q >= $signed(r_time_rd)) begin
            r_typ <= r_type_rd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((load_fire && rep) || i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] off;
        off = 32'sd0;
        unique case (r_qmode)
            tzol_pkg::QM_FIXED: off = 32'(i_fixed_offset);
            tzol_pkg::QM_TABLE: off = $signed(r_toff_rd);
            default:            off = 32'sd0;
        endcase
        if (load_fire && rep) begin
            o_result_kind    <= tzol_pkg::KIND_LOAD;
            o_status         <= rep_st;
            o_offset_seconds <= 32'sd0;
            o_abbrev_idx     <= 8'd0;
            o_local_seconds  <= 64'sd0;
        end else if (i_cmd.finish) begin
            o_result_kind    <= tzol_pkg::KIND_QUERY;
            o_status         <= tzol_pkg::ST_OK;
            o_offset_seconds <= off;
            o_abbrev_idx     <= (r_qmode == tzol_pkg::QM_TABLE) ? r_tabbr_rd : 8'd0;
            o_local_seconds  <= r_q + 64'(off);
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

// File: hdl/tzif_parse_and_offset_lookup_core.sv
// top level of the tzif parser and utc offset lookup
// load: bytes are taken back to back while the output register is free; a report, if any, is registered after its byte
// query: a walk over the transition time memory up to n = loaded transition count (up to MAX_TRANSITIONS),
// one entry per cycle, stopping at the first later time, then a type entry read and the sum
// fixed mode or no table: no walk or type read; one item in flight at a time
// reset: synchronous active low, clears parser, query control and config; tables are not cleared
module tzif_parse_and_offset_lookup_core #(
    parameter int MAX_TRANSITIONS = 512,
    parameter int MAX_TYPES       = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic signed [63:0] i_query_seconds,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_result_kind,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_offset_seconds,
    output logic [7:0]         o_abbrev_idx,
    output logic signed [63:0] o_local_seconds,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [17:0]        i_cfg_data
);

    tzol_pkg::t_dp_cmd  cmd;
    tzol_pkg::t_dp_stat stat;
    logic               r_fixed_mode;
    logic signed [17:0] r_fixed_offset;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_mode   <= 1'b0;
            r_fixed_offset <= 18'sd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tzol_pkg::CFG_FIXED_MODE:   r_fixed_mode   <= i_cfg_data[0];
                tzol_pkg::CFG_FIXED_OFFSET: r_fixed_offset <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_in_stall = !cmd.accept;

    tzol_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tzol_dp #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .MAX_TYPES       (MAX_TYPES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_in_valid       (i_in_valid),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_query_seconds  (i_query_seconds),
        .i_fixed_mode     (r_fixed_mode),
        .i_fixed_offset   (r_fixed_offset),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_result_kind    (o_result_kind),
        .o_status         (o_status),
        .o_offset_seconds (o_offset_seconds),
        .o_abbrev_idx     (o_abbrev_idx),
        .o_local_seconds  (o_local_seconds)
    );

endmodule

// File: hdl/tzol_checker.sv
// port-level checker for the tzif offset lookup, bound to the top level
module tzol_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_result_kind,
    input logic [2:0]         o_status,
    input logic signed [31:0] o_offset_seconds,
    input logic signed [63:0] o_local_seconds,
    input logic               o_cfg_ready
);

    // a held result blocks new items
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("item accepted while a result is held");

    // a stalled result keeps its value
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_local_seconds)
                                          && $stable(o_status)))
        else $error("stalled result changed");

    // query answers carry status ok, load reports carry no offset
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind ? (o_status == tzol_pkg::ST_OK)
                                       : (o_offset_seconds == 32'sd0 &&
                                          o_local_seconds == 64'sd0 &&
                                          o_status <= tzol_pkg::ST_TOO_LARGE)))
        else $error("result fields inconsistent with kind");

    // configuration port is always open
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind tzif_parse_and_offset_lookup_core tzol_checker u_tzol_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_kind    (o_result_kind),
    .o_status         (o_status),
    .o_offset_seconds (o_offset_seconds),
    .o_local_seconds  (o_local_seconds),
    .o_cfg_ready      (o_cfg_ready)
);

// File: bench/tb_top.sv
// self-checking bench for the tzif parser and utc offset lookup core
`timescale 1ns / 100ps

// expected-result store and the mirror of the parser and lookup state
class tzol_scoreboard;
    typedef struct {
        logic        rkind;
        logic [2:0]  st;
        logic [31:0] off;
        logic [7:0]  abbr;
        logic [63:0] loc;
    } t_res;

    t_res        pending[$];
    int          errors;
    int          got_count;

    bit          fmode;
    logic [17:0] foff;
    tzol_pkg::t_phase phase;
    logic [39:0] bcnt;
    logic [63:0] shreg;
    logic [39:0] skip_len;
    logic [31:0] tcnt, tycnt, ccnt;
    bit          valid_tab;
    bit          bad_magic;
    logic [63:0] times_mem[512];
    logic [7:0]  types_mem[512];
    logic [31:0] offs_mem[16];
    logic [7:0]  abbrs_mem[16];

    function new();
        errors = 0;
        got_count = 0;
        fmode = 0;
        foff = '0;
        phase = tzol_pkg::PH_HDR1;
        bcnt = '0;
        shreg = '0;
        skip_len = '0;
        tcnt = '0;
        tycnt = '0;
        ccnt = '0;
        valid_tab = 0;
        bad_magic = 0;
    endfunction

    function void write_reg(logic idx, logic [17:0] v);
        if (idx == tzol_pkg::CFG_FIXED_MODE) fmode = v[0];
        else foff = v;
    endfunction

    // move to the next non-empty section, return 1 when the table is complete
    function bit open_section(tzol_pkg::t_phase from);
        bcnt = '0;
        shreg = '0;
        phase = tzol_pkg::enter_phase(from, tcnt, tycnt, ccnt);
        if (phase == tzol_pkg::PH_DONE) begin
            valid_tab = 1;
            return 1;
        end
        return 0;
    endfunction

    // one file byte; returns report status or -1
    function int parse_byte(logic [7:0] b);
        logic [39:0] pos;
        logic [7:0]  mg;
        logic [31:0] v;
        int          k;
        bit          second;
        pos = bcnt;
        case (phase)
            tzol_pkg::PH_HDR1, tzol_pkg::PH_HDR2: begin
                second = (phase == tzol_pkg::PH_HDR2);
                if (!second && pos == 0) begin
                    valid_tab = 0;
                    skip_len = '0;
                    bad_magic = 0;
                end
                shreg = {shreg[55:0], b};
                case (pos)
                    0: mg = 8'h54;
                    1: mg = 8'h5A;
                    2: mg = 8'h69;
                    default: mg = 8'h66;
                endcase
                if (pos < 4 && b != mg) bad_magic = 1;
                if (pos >= 20 && pos[1:0] == 2'd3) begin
                    k = (pos - 20) >> 2;
                    v = shreg[31:0];
                    if (!second) begin
                        case (k)
                            2: skip_len = skip_len + 40'(v) * 8;
                            3: skip_len = skip_len + 40'(v) * 5;
                            4: skip_len = skip_len + 40'(v) * 6;
                            default: skip_len = skip_len + 40'(v);
                        endcase
                    end else if (k == 3) tcnt = v;
                    else if (k == 4) tycnt = v;
                    else if (k == 5) ccnt = v;
                end
                bcnt = pos + 1;
                if (bcnt < 44) return -1;
                bcnt = '0;
                shreg = '0;
                if (bad_magic) begin
                    phase = tzol_pkg::PH_DRAIN;
                    return second ? tzol_pkg::ST_BAD_MAGIC2 : tzol_pkg::ST_BAD_MAGIC1;
                end
                if (!second) begin
                    phase = (skip_len == 0) ? tzol_pkg::PH_HDR2 : tzol_pkg::PH_SKIP1;
                    return -1;
                end
                if (tcnt > 512 || tycnt > 16) begin
                    phase = tzol_pkg::PH_DRAIN;
                    return tzol_pkg::ST_TOO_LARGE;
                end
                return open_section(tzol_pkg::PH_TIMES) ? tzol_pkg::ST_OK : -1;
            end
            tzol_pkg::PH_SKIP1: begin
                bcnt = pos + 1;
                if (bcnt >= skip_len) begin
                    bcnt = '0;
                    bad_magic = 0;
                    phase = tzol_pkg::PH_HDR2;
                end
                return -1;
            end
            tzol_pkg::PH_TIMES: begin
                shreg = {shreg[55:0], b};
                if (pos[2:0] == 3'd7) times_mem[pos[11:3]] = shreg;
                bcnt = pos + 1;
                if (bcnt >= 40'(tcnt) * 8)
                    return open_section(tzol_pkg::PH_TYPES) ? tzol_pkg::ST_OK : -1;
                return -1;
            end
            tzol_pkg::PH_TYPES: begin
                types_mem[pos[8:0]] = b;
                bcnt = pos + 1;
                if (bcnt >= 40'(tcnt))
                    return open_section(tzol_pkg::PH_TTINFO) ? tzol_pkg::ST_OK : -1;
                return -1;
            end
            tzol_pkg::PH_TTINFO: begin
                if (pos % 6 < 4) shreg = {shreg[55:0], b};
                if (pos % 6 == 3) offs_mem[(pos / 6) % 16] = shreg[31:0];
                if (pos % 6 == 5) abbrs_mem[(pos / 6) % 16] = b;
                bcnt = pos + 1;
                if (bcnt >= 40'(tycnt) * 6)
                    return open_section(tzol_pkg::PH_CHARS) ? tzol_pkg::ST_OK : -1;
                return -1;
            end
            tzol_pkg::PH_CHARS: begin
                bcnt = pos + 1;
                if (bcnt >= 40'(ccnt))
                    return open_section(tzol_pkg::PH_DONE) ? tzol_pkg::ST_OK : -1;
                return -1;
            end
            default: return -1;
        endcase
    endfunction

    // note an accepted input item and queue what it should produce
    function void note_item(logic kind, logic [7:0] b, logic last, logic [63:0] q);
        t_res r;
        int   st;
        int   n;
        logic [7:0] typ;
        bit   found;
        logic signed [63:0] off;
        if (kind == tzol_pkg::KIND_LOAD) begin
            st = parse_byte(b);
            if (st < 0 && last && phase != tzol_pkg::PH_DONE
                && phase != tzol_pkg::PH_DRAIN) begin
                st = tzol_pkg::ST_TRUNCATED;
                valid_tab = 0;
            end
            if (last) begin
                phase = tzol_pkg::PH_HDR1;
                bcnt = '0;
                shreg = '0;
            end
            if (st < 0) return;
            r = '{tzol_pkg::KIND_LOAD, 3'(st), '0, '0, '0};
            pending.push_back(r);
            return;
        end
        off = 0;
        r.abbr = '0;
        if (fmode) begin
            off = 64'(signed'(foff));
        end else if (valid_tab && tycnt != 0) begin
            n = (tcnt < 512) ? int'(tcnt) : 512;
            typ = '0;
            found = 0;
            for (int i = 0; i < n; i++) begin
                if ($signed(q) >= $signed(times_mem[i])) begin
                    typ = types_mem[i];
                    found = 1;
                end else break;
            end
            if (!found || 32'(typ) >= tycnt || typ >= 16) typ = '0;
            off = 64'(signed'(offs_mem[typ[3:0]]));
            r.abbr = abbrs_mem[typ[3:0]];
        end
        r.rkind = tzol_pkg::KIND_QUERY;
        r.st = tzol_pkg::ST_OK;
        r.off = off[31:0];
        r.loc = q + off;
        pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic rk, logic [2:0] st, logic [31:0] off,
                      logic [7:0] abbr, logic [63:0] loc);
        t_res e;
        got_count++;
        if (pending.size() == 0) begin
            report("unexpected result", {63'd0, rk}, 64'd0);
            return;
        end
        e = pending.pop_front();
        if (rk !== e.rkind) report("result_kind", 64'(rk), 64'(e.rkind));
        if (st !== e.st) report("status", 64'(st), 64'(e.st));
        if (off !== e.off) report("offset_seconds", 64'(off), 64'(e.off));
        if (abbr !== e.abbr) report("abbrev_idx", 64'(abbr), 64'(e.abbr));
        if (loc !== e.loc) report("local_seconds", loc, e.loc);
    endtask
endclass

module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic signed [63:0] i_query_seconds;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_result_kind;
    logic [2:0]         o_status;
    logic signed [31:0] o_offset_seconds;
    logic [7:0]         o_abbrev_idx;
    logic signed [63:0] o_local_seconds;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [17:0]        i_cfg_data;

    tzol_scoreboard sb;
    int  cycles;
    bit  calm;          // no idling in the last part
    int  out_hold;
    int  sent;
    byte unsigned file_buf[$];
    logic [63:0] time_pool[$];

    localparam int CYCLE_LIMIT = 3000000;

    tzif_parse_and_offset_lookup_core uut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall bursts, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_result_kind, o_status, o_offset_seconds, o_abbrev_idx,
                            o_local_seconds);
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            out_hold <= $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // drive one item and wait for its acceptance; valid stays up for the next item
    task automatic send_item(logic kind, logic [7:0] b, logic last, logic [63:0] q);
        int gap;
        if (!calm && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= b;
        i_last_byte <= last;
        i_query_seconds <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(kind, b, last, q);
        sent++;
    endtask

    task automatic ask(logic [63:0] q);
        send_item(tzol_pkg::KIND_QUERY, 8'($urandom), 1'($urandom), q);
    endtask

    // wait until every expected result is in, then let the core settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [17:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put32(logic [31:0] v);
        for (int i = 3; i >= 0; i--) file_buf.push_back(v[i*8 +: 8]);
    endtask

    task automatic put_header(bit bad, logic [31:0] c[6]);
        put32(bad ? 32'h545A6967 : 32'h545A6966);
        file_buf.push_back(8'h32);
        repeat (15) file_buf.push_back(8'($urandom));
        for (int i = 0; i < 6; i++) put32(c[i]);
    endtask

    // build a well-formed file; flaws: 1 bad magic1, 2 bad magic2, 4 too large
    task automatic build_file(int nt, int nty, int nc, int flaw, bit sorted);
        logic [31:0] c[6];
        logic [63:0] t;
        int v1t, v1ty;
        file_buf.delete();
        time_pool.delete();
        v1t = $urandom_range(0, 3);
        v1ty = $urandom_range(0, 2);
        c = '{0, 0, 0, v1t, v1ty, $urandom_range(0, 3)};
        put_header(flaw == 1, c);
        repeat (v1t * 5 + v1ty * 6 + c[5]) file_buf.push_back(8'($urandom));
        c = '{$urandom_range(0, 1), $urandom_range(0, 1), 0, nt, nty, nc};
        if (flaw == 4) begin
            if ($urandom_range(0, 1)) c[3] = 513 + $urandom_range(0, 2);
            else c[4] = $urandom_range(0, 1) ? 17 : 32'hFFFF_FFFF;
        end
        put_header(flaw == 2, c);
        if (flaw == 4) return;
        t = {$urandom, $urandom} >> $urandom_range(1, 40);
        if ($urandom_range(0, 1)) t = -t;
        for (int i = 0; i < nt; i++) begin
            if (sorted) t = t + $urandom_range(1, 100000);
            else t = {$urandom, $urandom};
            time_pool.push_back(t);
            put32(t[63:32]);
            put32(t[31:0]);
        end
        for (int i = 0; i < nt; i++)
            file_buf.push_back(8'($urandom_range(0, 5) == 0 ? $urandom
                                                             : $urandom_range(0, nty)));
        for (int i = 0; i < nty; i++) begin
            put32($signed($urandom_range(0, 172800)) - 86400);
            file_buf.push_back(8'($urandom_range(0, 1)));
            file_buf.push_back(8'($urandom));
        end
        repeat (nc) file_buf.push_back(8'($urandom));
    endtask

    // stream the file; cut truncates early, trail adds footer bytes
    task automatic send_file(int cut, int trail);
        int n;
        n = (cut > 0 && cut < file_buf.size()) ? cut : file_buf.size();
        repeat (trail) file_buf.push_back(8'($urandom));
        if (cut == 0) n = file_buf.size();
        for (int i = 0; i < n; i++)
            send_item(tzol_pkg::KIND_LOAD, file_buf[i], i == n - 1, {$urandom, $urandom});
    endtask

    task automatic query_burst(int cnt);
        logic [63:0] q;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 5))
                0: q = {$urandom, $urandom};
                1: q = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                            : 64'h7FFF_FFFF_FFFF_FFFF;
                default: begin
                    if (time_pool.size() == 0) q = {$urandom, $urandom};
                    else begin
                        q = time_pool[$urandom_range(0, time_pool.size() - 1)];
                        q = q + $signed($urandom_range(0, 4)) - 2;
                    end
                end
            endcase
            ask(q);
        end
    endtask

    int nt;

    initial begin
        sb = new();
        cycles = 0;
        calm = 0;
        out_hold = 0;
        sent = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= tzol_pkg::KIND_LOAD;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        i_query_seconds <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= tzol_pkg::CFG_FIXED_MODE;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no table, extremes of the query
        ask(64'h8000_0000_0000_0000);
        ask(64'h7FFF_FFFF_FFFF_FFFF);
        ask(64'h0);
        // fixed mode at both extremes, wrapping local time
        drain_results();
        write_reg(tzol_pkg::CFG_FIXED_MODE, 18'd1);
        write_reg(tzol_pkg::CFG_FIXED_OFFSET, 18'(86400));
        ask(64'h7FFF_FFFF_FFFF_FFFF);
        drain_results();
        write_reg(tzol_pkg::CFG_FIXED_OFFSET, 18'(-86400));
        ask(64'h8000_0000_0000_0000);
        ask(64'hFFFF_FFFF_FFFF_FFFF);
        drain_results();
        write_reg(tzol_pkg::CFG_FIXED_MODE, 18'd0);
        // error loads: bad first magic, bad second magic, too large, truncated
        build_file(1, 1, 1, 1, 1);
        send_file(0, 2);
        build_file(1, 1, 1, 2, 1);
        send_file(0, 0);
        build_file(1, 1, 1, 4, 1);
        send_file(0, 1);
        build_file(2, 2, 2, 0, 1);
        send_file(20, 0);
        ask(64'd5);
        // empty table: no types, then zero transitions with one type
        build_file(0, 0, 0, 0, 1);
        send_file(0, 0);
        ask(64'd7);
        build_file(0, 1, 0, 0, 1);
        send_file(0, 3);
        query_burst(3);

        // random files with query bursts
        while (sent < 1170) begin
            drain_results();
            if ($urandom_range(0, 4) == 0) begin
                write_reg(tzol_pkg::CFG_FIXED_MODE, 18'($urandom_range(0, 3) == 0));
                write_reg(tzol_pkg::CFG_FIXED_OFFSET,
                          18'($signed($urandom_range(0, 172800)) - 86400));
            end
            if (sent > 950) calm = 1;
            nt = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 64) : $urandom_range(0, 12);
            case ($urandom_range(0, 9))
                0: build_file(nt, $urandom_range(0, 16), $urandom_range(0, 6),
                              $urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 1) ? 2 : 4),
                              1);
                default: build_file(nt, $urandom_range(0, 16), $urandom_range(0, 6), 0,
                                    $urandom_range(0, 5) != 0);
            endcase
            if ($urandom_range(0, 7) == 0)
                send_file($urandom_range(1, file_buf.size()), 0);
            else
                send_file(0, $urandom_range(0, 4));
            query_burst($urandom_range(4, 20));
        end

        drain_results();
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
